[hw/rtl/npsg_pkg.sv]
// ----------------------------------------------------------------------------
// npsg_pkg
// Types and constants shared by the nearest-place block and its bench.
// ----------------------------------------------------------------------------
`default_nettype none
package npsg_pkg;

    // table sizes and coordinate width are tied to the fixed beat layout
    localparam int POINT_SLOTS   = 64;
    localparam int SEGMENT_SLOTS = 128;
    localparam int COORD_BITS    = 24;

    localparam logic [1:0] REQ_POINT   = 2'd0;
    localparam logic [1:0] REQ_SEGMENT = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PT_RD,
        ST_PT_DIST,
        ST_PT_SQ,
        ST_PT_CMP,
        ST_SG_RD,
        ST_SG_PRD,
        ST_SG_LEN,
        ST_SG_DOT,
        ST_SG_CLAMP,
        ST_SG_DIV,
        ST_SG_LERP,
        ST_SG_PLACE,
        ST_SG_DIST,
        ST_SG_SQ,
        ST_SG_CMP,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/nearest_place_on_segment_graph.sv]
// ----------------------------------------------------------------------------
// nearest_place_on_segment_graph
// Point and segment tables in RAM; a query scans both and returns the
// nearest place (point or clamped projection onto a segment).
// Query duration is set by the sequential scan and the bit-serial
// projection divider.
// One item at a time; the input is held off until the result beat is taken.
// Reset: asynchronous, clears present/usable bits and control; RAM holds garbage.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_place_on_segment_graph #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type
    input  wire logic [1:0]  s_tuser,
    // slot, coord_x, coord_y, start_point, end_point, in_contact,
    // entry_valid; zero pad to 72 bits
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found
    output logic             m_tuser,
    // place_x, place_y, near_start, near_end; zero pad to 64 bits
    output logic [63:0]      m_tdata
);

    localparam int PW = $clog2(npsg_pkg::POINT_SLOTS);
    localparam int SW = $clog2(npsg_pkg::SEGMENT_SLOTS);
    localparam int CB = npsg_pkg::COORD_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int DB = CB + 1;          // difference
    localparam int QB = 2 * DB + 1;      // squared sum / dot
    localparam int FCW = $clog2(FB + 1);

    // field unpack
    logic [1:0]         req_type;
    logic [6:0]         in_slot;
    logic signed [23:0] in_x, in_y;
    logic [5:0]         in_sp, in_ep;
    logic               in_contact, in_valid;
    assign req_type   = s_tuser;
    assign in_slot    = s_tdata[6:0];
    assign in_x       = s_tdata[30:7];
    assign in_y       = s_tdata[54:31];
    assign in_sp      = s_tdata[60:55];
    assign in_ep      = s_tdata[66:61];
    assign in_contact = s_tdata[67];
    assign in_valid   = s_tdata[68];

    logic accept;
    npsg_pkg::state_t state_reg, state_next;
    assign s_tready = (state_reg == npsg_pkg::ST_IDLE) && !m_tvalid;
    assign accept   = s_tvalid && s_tready;

    logic pt_wr, sg_wr;
    assign pt_wr = accept && req_type == npsg_pkg::REQ_POINT
                   && {25'd0, in_slot} < 32'(npsg_pkg::POINT_SLOTS);
    assign sg_wr = accept && req_type == npsg_pkg::REQ_SEGMENT
                   && {25'd0, in_slot} < 32'(npsg_pkg::SEGMENT_SLOTS)
                   && {26'd0, in_sp} < 32'(npsg_pkg::POINT_SLOTS)
                   && {26'd0, in_ep} < 32'(npsg_pkg::POINT_SLOTS);

    // valid bits
    logic [npsg_pkg::POINT_SLOTS-1:0]   present_reg;
    logic [npsg_pkg::SEGMENT_SLOTS-1:0] usable_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            usable_reg  <= '0;
        end
        else
        begin
            if (pt_wr)
                present_reg[in_slot[PW-1:0]] <= in_valid;
            if (sg_wr)
                usable_reg[in_slot[SW-1:0]] <= in_valid && in_contact;
        end
    end

    // memories
    logic [PW-1:0]        pt_raddr;
    logic [2*CB-1:0]      pt_rdata;
    logic [SW-1:0]        sg_raddr;
    logic [2*PW-1:0]      sg_rdata;
    logic signed [CB-1:0] wr_x, wr_y;
    assign wr_x = CB'(in_x);
    assign wr_y = CB'(in_y);

    npsg_ram #(.WIDTH(2 * CB), .DEPTH(npsg_pkg::POINT_SLOTS)) u_pt_ram (
        .clk(clk), .we(pt_wr), .waddr(in_slot[PW-1:0]), .wdata({wr_y, wr_x}),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );
    npsg_ram #(.WIDTH(2 * PW), .DEPTH(npsg_pkg::SEGMENT_SLOTS)) u_sg_ram (
        .clk(clk), .we(sg_wr), .waddr(in_slot[SW-1:0]),
        .wdata({in_ep[PW-1:0], in_sp[PW-1:0]}),
        .raddr(sg_raddr), .rdata(sg_rdata)
    );

    logic signed [CB-1:0] rd_x, rd_y;
    assign rd_x = pt_rdata[CB-1:0];
    assign rd_y = pt_rdata[2*CB-1:CB];

    // datapath registers
    logic signed [CB-1:0] qx_reg, qy_reg;
    logic [PW:0]          pi_reg, pi_next;
    logic [SW:0]          si_reg, si_next;
    logic [PW-1:0]        s_reg, e_reg;
    logic signed [CB-1:0] sx_reg, sy_reg;
    logic signed [CB-1:0] cx_reg, cy_reg;      // candidate place
    logic signed [DB-1:0] ax_reg, ay_reg, dx_reg, dy_reg;
    logic signed [QB-1:0] m0_reg, m1_reg;
    logic [QB-1:0]        len_reg, dot_reg, rem_reg, dist_reg;
    logic [FB:0]          t_reg;
    logic [FCW-1:0]       fc_reg;
    logic                 have_reg;
    logic [QB-1:0]        best_reg;
    logic signed [CB-1:0] bx_reg, by_reg;
    logic [PW-1:0]        bs_reg, be_reg;
    logic [63:0]          out_reg;
    logic                 out_found_reg;
    logic                 ov_reg;

    // combinational helpers
    logic [QB:0]          rem2;
    logic signed [DB+FB+1:0] lx, ly;
    logic signed [DB+FB+1:0] rnd;
    assign rem2  = {rem_reg, 1'b0};
    assign rnd   = (DB+FB+2)'(1) <<< (FB - 1);
    assign lx    = (DB+FB+2)'(m0_reg) + rnd;
    assign ly    = (DB+FB+2)'(m1_reg) + rnd;

    always_comb
    begin
        state_next = state_reg;
        pi_next    = pi_reg;
        si_next    = si_reg;
        pt_raddr   = pi_reg[PW-1:0];
        sg_raddr   = si_reg[SW-1:0];
        unique case (state_reg)
            npsg_pkg::ST_IDLE:
                if (accept && req_type == npsg_pkg::REQ_QUERY)
                begin
                    pi_next    = '0;
                    state_next = npsg_pkg::ST_PT_RD;
                end
            npsg_pkg::ST_PT_RD:
                if ({1'b0, pi_reg} >= (PW+2)'(npsg_pkg::POINT_SLOTS))
                begin
                    si_next    = '0;
                    state_next = npsg_pkg::ST_SG_RD;
                end
                else if (!present_reg[pi_reg[PW-1:0]])
                    pi_next = pi_reg + 1'b1;
                else
                    state_next = npsg_pkg::ST_PT_DIST;
            npsg_pkg::ST_PT_DIST:
                state_next = npsg_pkg::ST_PT_SQ;
            npsg_pkg::ST_PT_SQ:
                state_next = npsg_pkg::ST_PT_CMP;
            npsg_pkg::ST_PT_CMP:
            begin
                pi_next    = pi_reg + 1'b1;
                state_next = npsg_pkg::ST_PT_RD;
            end
            npsg_pkg::ST_SG_RD:
                if ({1'b0, si_reg} >= (SW+2)'(npsg_pkg::SEGMENT_SLOTS))
                    state_next = npsg_pkg::ST_OUT;
                else if (!usable_reg[si_reg[SW-1:0]])
                    si_next = si_reg + 1'b1;
                else
                    state_next = npsg_pkg::ST_SG_PRD;
            npsg_pkg::ST_SG_PRD:
            begin
                // segment data valid now: read start, then end
                pt_raddr   = sg_rdata[PW-1:0];
                state_next = npsg_pkg::ST_SG_LEN;
            end
            npsg_pkg::ST_SG_LEN:
            begin
                pt_raddr   = e_reg;
                state_next = npsg_pkg::ST_SG_DOT;
            end
            npsg_pkg::ST_SG_DOT:
                state_next = npsg_pkg::ST_SG_CLAMP;
            npsg_pkg::ST_SG_CLAMP:
                state_next = npsg_pkg::ST_SG_DIV;
            npsg_pkg::ST_SG_DIV:
                if (fc_reg == '0)
                    state_next = npsg_pkg::ST_SG_LERP;
            npsg_pkg::ST_SG_LERP:
                state_next = npsg_pkg::ST_SG_PLACE;
            npsg_pkg::ST_SG_PLACE:
                state_next = npsg_pkg::ST_SG_DIST;
            npsg_pkg::ST_SG_DIST:
                state_next = npsg_pkg::ST_SG_SQ;
            npsg_pkg::ST_SG_SQ:
                state_next = npsg_pkg::ST_SG_CMP;
            npsg_pkg::ST_SG_CMP:
            begin
                si_next    = si_reg + 1'b1;
                state_next = npsg_pkg::ST_SG_RD;
            end
            npsg_pkg::ST_OUT:
                if (!ov_reg)
                    state_next = npsg_pkg::ST_IDLE;
            default:
                state_next = npsg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= npsg_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            if (state_reg == npsg_pkg::ST_IDLE && accept && req_type == npsg_pkg::REQ_QUERY)
                have_reg <= 1'b0;
            if ((state_reg == npsg_pkg::ST_PT_CMP || state_reg == npsg_pkg::ST_SG_CMP)
                && (!have_reg || dist_reg < best_reg))
                have_reg <= 1'b1;
            if (state_reg == npsg_pkg::ST_OUT && !ov_reg)
                ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg <= pi_next;
        si_reg <= si_next;
        unique case (state_reg)
            npsg_pkg::ST_IDLE:
            begin
                qx_reg <= CB'(in_x);
                qy_reg <= CB'(in_y);
            end
            npsg_pkg::ST_PT_DIST:
            begin
                cx_reg <= rd_x;
                cy_reg <= rd_y;
                s_reg  <= pi_reg[PW-1:0];
                e_reg  <= pi_reg[PW-1:0];
                dx_reg <= DB'(rd_x) - DB'(qx_reg);
                dy_reg <= DB'(rd_y) - DB'(qy_reg);
            end
            npsg_pkg::ST_SG_PRD:
            begin
                s_reg <= sg_rdata[PW-1:0];
                e_reg <= sg_rdata[2*PW-1:PW];
            end
            npsg_pkg::ST_SG_LEN:
            begin
                sx_reg <= rd_x;
                sy_reg <= rd_y;
            end
            npsg_pkg::ST_SG_DOT:
            begin
                ax_reg <= DB'(rd_x) - DB'(sx_reg);
                ay_reg <= DB'(rd_y) - DB'(sy_reg);
                dx_reg <= DB'(qx_reg) - DB'(sx_reg);
                dy_reg <= DB'(qy_reg) - DB'(sy_reg);
            end
            npsg_pkg::ST_SG_CLAMP:
            begin
                // squared length and dot are formed here, two product pairs
                len_reg <= QB'(ax_reg * ax_reg) + QB'(ay_reg * ay_reg);
                dot_reg <= QB'(dx_reg * ax_reg) + QB'(dy_reg * ay_reg);
                fc_reg  <= FCW'(FB);
                t_reg   <= '0;
                rem_reg <= '0;
            end
            npsg_pkg::ST_SG_DIV:
            begin
                if (fc_reg == FCW'(FB))
                begin
                    // decide clamps on first step
                    if (len_reg == '0)
                    begin
                        t_reg  <= '0;
                        fc_reg <= '0;
                    end
                    else if (dot_reg[QB-1] || dot_reg == '0)
                    begin
                        t_reg  <= '0;
                        fc_reg <= '0;
                    end
                    else if (dot_reg >= len_reg)
                    begin
                        t_reg  <= (FB+1)'(1) << FB;
                        fc_reg <= '0;
                    end
                    else
                    begin
                        fc_reg <= fc_reg - 1'b1;
                        if ({dot_reg, 1'b0} >= {1'b0, len_reg})
                        begin
                            rem_reg <= QB'({dot_reg, 1'b0} - {1'b0, len_reg});
                            t_reg   <= (FB+1)'(1);
                        end
                        else
                            rem_reg <= QB'({dot_reg, 1'b0});
                    end
                end
                else if (fc_reg != '0)
                begin
                    fc_reg <= fc_reg - 1'b1;
                    if (rem2 >= {1'b0, len_reg})
                    begin
                        rem_reg <= QB'(rem2 - {1'b0, len_reg});
                        t_reg   <= {t_reg[FB-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= QB'(rem2);
                        t_reg   <= {t_reg[FB-1:0], 1'b0};
                    end
                end
            end
            npsg_pkg::ST_SG_LERP:
            begin
                m0_reg <= QB'(ax_reg * $signed({1'b0, t_reg}));
                m1_reg <= QB'(ay_reg * $signed({1'b0, t_reg}));
            end
            npsg_pkg::ST_SG_PLACE:
            begin
                // arithmetic shift floors; adds rounding half
                cx_reg <= sx_reg + CB'(lx >>> FB);
                cy_reg <= sy_reg + CB'(ly >>> FB);
            end
            npsg_pkg::ST_SG_DIST:
            begin
                dx_reg <= DB'(cx_reg) - DB'(qx_reg);
                dy_reg <= DB'(cy_reg) - DB'(qy_reg);
            end
            default:
            begin
            end
        endcase
        if (state_reg == npsg_pkg::ST_PT_CMP || state_reg == npsg_pkg::ST_SG_CMP)
        begin
            if (!have_reg || dist_reg < best_reg)
            begin
                best_reg <= dist_reg;
                bx_reg   <= cx_reg;
                by_reg   <= cy_reg;
                bs_reg   <= s_reg;
                be_reg   <= e_reg;
            end
        end
        if (state_reg == npsg_pkg::ST_OUT && !ov_reg)
        begin
            out_found_reg <= have_reg;
            if (have_reg)
                out_reg <= {4'd0, 6'(be_reg), 6'(bs_reg), 24'(by_reg), 24'(bx_reg)};
            else
                out_reg <= '0;
        end
    end

    // squared distance, registered from the settled dx/dy in the SQ states
    always_ff @(posedge clk)
    begin
        if (state_reg == npsg_pkg::ST_PT_SQ || state_reg == npsg_pkg::ST_SG_SQ)
            dist_reg <= QB'(dx_reg * dx_reg) + QB'(dy_reg * dy_reg);
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire

[hw/rtl/npsg_ram.sv]
// ----------------------------------------------------------------------------
// npsg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module npsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[bench/tb_nearest_place_on_segment_graph.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_place_on_segment_graph
// Self-checking bench: fills the point and segment tables, fires queries and
// checks every answer against a behavioral predictor of the nearest-place scan.
// ----------------------------------------------------------------------------
module tb_nearest_place_on_segment_graph;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int NPTS = 64;
    localparam int NSEG = 128;
    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        logic [1:0]         req;
        logic [6:0]         slot;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [5:0]         sp;
        logic [5:0]         ep;
        logic               contact;
        logic               valid;
        bit                 drain;
    } req_item_t;

    typedef struct {
        logic               found;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [5:0]         ns;
        logic [5:0]         ne;
    } place_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tuser;
    logic [63:0] m_tdata;

    nearest_place_on_segment_graph dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // predictor copy of the tables
    longint pt_x [NPTS];
    longint pt_y [NPTS];
    bit     pt_on [NPTS];
    int     sg_s [NSEG];
    int     sg_e [NSEG];
    bit     sg_on [NSEG];

    // stimulus-side knowledge of which points hold defined coordinates
    bit gen_written [NPTS];

    req_item_t pending_reqs [$];
    place_t    expected_places [$];
    req_item_t cur_req;

    int  errors = 0;
    int  queries_sent = 0;
    int  found_count = 0;
    int  segment_wins = 0;
    int  req_gap = 0;
    int  rdy_gap = 0;
    bit  no_idle = 1'b0;
    longint cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [71:0] pack_req(req_item_t it);
        return {3'd0, it.valid, it.contact, it.ep, it.sp, it.cy, it.cx, it.slot};
    endfunction

    function automatic longint dist_sq(longint x, longint y, longint qx, longint qy);
        return (x - qx) * (x - qx) + (y - qy) * (y - qy);
    endfunction

    // start + round(along * t / 2^FRAC), halves up; >>> gives the floor
    function automatic longint lerp_axis(longint start, longint along, longint t);
        longint p;
        p = along * t + (longint'(1) << (FRAC - 1));
        return start + (p >>> FRAC);
    endfunction

    task automatic apply_request(req_item_t it);
        place_t       res;
        bit           have;
        longint       best, d, qx, qy, sx, sy, ax, ay, len2, dot, t, px, py;
        logic [127:0] num;
        int           s, e;
        qx = it.cx;
        qy = it.cy;
        case (it.req)
            npsg_pkg::REQ_POINT:
                if (it.slot < NPTS)
                begin
                    pt_x[it.slot]  = qx;
                    pt_y[it.slot]  = qy;
                    pt_on[it.slot] = it.valid;
                end
            npsg_pkg::REQ_SEGMENT:
            begin
                sg_s[it.slot]  = it.sp;
                sg_e[it.slot]  = it.ep;
                sg_on[it.slot] = it.valid & it.contact;
            end
            npsg_pkg::REQ_QUERY:
            begin
                have = 1'b0;
                best = 0;
                res = '{1'b0, 24'sd0, 24'sd0, 6'd0, 6'd0};
                for (int i = 0; i < NPTS; i++)
                begin
                    if (!pt_on[i])
                        continue;
                    d = dist_sq(pt_x[i], pt_y[i], qx, qy);
                    if (have && d >= best)
                        continue;
                    have = 1'b1;
                    best = d;
                    res = '{1'b1, pt_x[i][23:0], pt_y[i][23:0], 6'(i), 6'(i)};
                end
                for (int i = 0; i < NSEG; i++)
                begin
                    if (!sg_on[i])
                        continue;
                    s = sg_s[i];
                    e = sg_e[i];
                    sx = pt_x[s];
                    sy = pt_y[s];
                    ax = pt_x[e] - sx;
                    ay = pt_y[e] - sy;
                    len2 = ax * ax + ay * ay;
                    px = sx;
                    py = sy;
                    if (len2 != 0)
                    begin
                        dot = (qx - sx) * ax + (qy - sy) * ay;
                        if (dot <= 0)
                            t = 0;
                        else if (dot >= len2)
                            t = longint'(1) << FRAC;
                        else
                        begin
                            num = (128'(dot) << FRAC) / 128'(len2);
                            t = longint'(num);
                        end
                        px = lerp_axis(sx, ax, t);
                        py = lerp_axis(sy, ay, t);
                    end
                    d = dist_sq(px, py, qx, qy);
                    if (have && d >= best)
                        continue;
                    have = 1'b1;
                    best = d;
                    res = '{1'b1, px[23:0], py[23:0], 6'(s), 6'(e)};
                end
                expected_places.push_back(res);
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // ---------------- stimulus builders ----------------
    function automatic logic signed [23:0] rand_coord();
        if ($urandom_range(0, 9) < 7)
            return 24'(int'($urandom_range(0, 8191)) - 4096);
        return 24'($urandom);
    endfunction

    task automatic add_point(int slot, logic signed [23:0] x, logic signed [23:0] y, bit v);
        req_item_t it;
        it = '{npsg_pkg::REQ_POINT, 7'(slot), x, y, 6'($urandom), 6'($urandom),
               1'($urandom), v, 1'b0};
        if (slot < NPTS)
            gen_written[slot] = 1'b1;
        pending_reqs.push_back(it);
    endtask

    // a usable segment may only join points that hold defined coordinates
    task automatic add_segment(int slot, int sp, int ep, bit c, bit v);
        req_item_t it;
        if (c && v && !(gen_written[sp] && gen_written[ep]))
            c = 1'b0;
        it = '{npsg_pkg::REQ_SEGMENT, 7'(slot), 24'($urandom), 24'($urandom), 6'(sp),
               6'(ep), c, v, 1'b0};
        pending_reqs.push_back(it);
    endtask

    task automatic add_query(logic signed [23:0] x, logic signed [23:0] y);
        req_item_t it;
        it = '{npsg_pkg::REQ_QUERY, 7'($urandom), x, y, 6'($urandom), 6'($urandom),
               1'($urandom), 1'($urandom), 1'b0};
        pending_reqs.push_back(it);
    endtask

    function automatic int written_slot();
        int s;
        s = $urandom_range(0, NPTS - 1);
        for (int k = 0; k < NPTS; k++)
            if (gen_written[(s + k) % NPTS])
                return (s + k) % NPTS;
        return 0;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            req_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_request(cur_req);
            if (s_tvalid && !s_tready)
                ;  // hold the beat
            else if (req_gap > 0)
            begin
                req_gap  <= req_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain &&
                      (expected_places.size() != 0 ||
                       (s_tvalid && cur_req.req == npsg_pkg::REQ_QUERY))))
                s_tvalid <= 1'b0;
            else
            begin
                cur_req = pending_reqs.pop_front();
                s_tuser  <= cur_req.req;
                s_tdata  <= pack_req(cur_req);
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    no_idle = ~no_idle;
                req_gap <= pick_gap();
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        place_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rdy_gap  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_places.size() == 0)
                begin
                    errors++;
                    $display("[%0t] result beat with nothing expected", $realtime);
                end
                else
                begin
                    want = expected_places.pop_front();
                    if (m_tuser !== want.found)
                        report_mismatch("found", m_tuser, want.found);
                    if (m_tdata[23:0] !== want.px)
                        report_mismatch("place_x", m_tdata[23:0], want.px);
                    if (m_tdata[47:24] !== want.py)
                        report_mismatch("place_y", m_tdata[47:24], want.py);
                    if (m_tdata[53:48] !== want.ns)
                        report_mismatch("near_start", m_tdata[53:48], want.ns);
                    if (m_tdata[59:54] !== want.ne)
                        report_mismatch("near_end", m_tdata[59:54], want.ne);
                    if (want.found)
                        found_count++;
                    if (want.found && want.ns != want.ne)
                        segment_wins++;
                end
            end
            if (rdy_gap > 0)
            begin
                rdy_gap  <= rdy_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    rdy_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("nearest_place_on_segment_graph regression: fail");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        int r, n;
        req_item_t it;
        foreach (pt_on[i])
        begin
            pt_on[i] = 1'b0;
            pt_x[i] = 0;
            pt_y[i] = 0;
            gen_written[i] = 1'b0;
        end
        foreach (sg_on[i])
        begin
            sg_on[i] = 1'b0;
            sg_s[i] = 0;
            sg_e[i] = 0;
        end

        // directed part
        add_query(24'sd0, 24'sd0);                       // empty store
        add_point(100, 24'sd10, 24'sd10, 1'b1);          // out-of-range slot, ignored
        add_query(24'sd10, 24'sd10);
        add_point(0, 24'sh7FFFFF, 24'sh800000, 1'b1);
        add_point(63, 24'sh800000, 24'sh7FFFFF, 1'b1);
        add_query(24'sh7FFFFF, 24'sh7FFFFF);
        add_point(1, 24'sd0, 24'sd0, 1'b1);
        add_point(2, 24'sd2560, 24'sd0, 1'b1);
        add_point(3, 24'sd100, 24'sd100, 1'b1);
        add_segment(0, 1, 2, 1'b1, 1'b1);
        add_query(24'sd1000, 24'sd700);                  // interior projection
        add_query(-24'sd900, 24'sd50);                   // clamped at start
        add_query(24'sd9000, -24'sd50);                  // clamped at end
        add_segment(1, 3, 3, 1'b1, 1'b1);                // degenerate
        add_query(24'sd120, 24'sd130);
        add_segment(2, 0, 63, 1'b0, 1'b1);               // not in contact
        add_point(2, 24'sd2560, 24'sd0, 1'b0);           // remove an end point
        add_query(24'sd2600, 24'sd10);
        add_segment(0, 1, 2, 1'b1, 1'b0);                // remove segment
        add_query(24'sd2600, 24'sd10);
        it = '{REQ_UNUSED, 7'd5, 24'sd1, 24'sd1, 6'd1, 6'd1, 1'b1, 1'b1, 1'b0};
        pending_reqs.push_back(it);
        add_query(24'sh800000, 24'sh800000);
        pending_reqs[pending_reqs.size() - 1].drain = 1'b1;

        // random part
        n = 0;
        while (n < 1300)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                add_point($urandom_range(0, 9) == 0 ? $urandom_range(64, 127)
                                                    : $urandom_range(0, NPTS - 1),
                          rand_coord(), rand_coord(), $urandom_range(0, 5) != 0);
            else if (r < 65)
            begin
                if ($urandom_range(0, 4) == 0)
                    add_segment($urandom_range(0, NSEG - 1), $urandom_range(0, 63),
                                $urandom_range(0, 63), 1'($urandom), 1'($urandom));
                else
                    add_segment($urandom_range(0, NSEG - 1), written_slot(), written_slot(),
                                $urandom_range(0, 4) != 0, $urandom_range(0, 5) != 0);
            end
            else if (r < 92)
                add_query(rand_coord(), rand_coord());
            else if (r < 94)
            begin
                it = '{REQ_UNUSED, 7'($urandom), 24'($urandom), 24'($urandom), 6'($urandom),
                       6'($urandom), 1'($urandom), 1'($urandom), 1'b0};
                pending_reqs.push_back(it);
                n--;
            end
            else
            begin
                // wipe a random point
                add_point($urandom_range(0, NPTS - 1), rand_coord(), rand_coord(), 1'b0);
            end
            if (n == 650)
                pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
            n++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        @(posedge clk);
        wait (!s_tvalid);
        wait (expected_places.size() == 0);
        repeat (200) @(posedge clk);

        $display("covered %0d queries, %0d found a place, %0d won by a segment",
                 queries_sent, found_count, segment_wins);
        if (errors == 0 && expected_places.size() == 0)
            $display("nearest_place_on_segment_graph regression: pass");
        else
            $display("nearest_place_on_segment_graph regression: fail");
        $finish;
    end

endmodule
